// ----- rtl/core/rty_pkg.sv -----
// Shared types, constants and codes of the RGB to YUV 4:2:0 converter.
`default_nettype none

package rty_pkg;

  // Largest image dimension that the counters are sized for.
  localparam int RTY_MAX_DIM = 4096;

  // Configuration port.
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     RESET_WIDTH      = 13'd640;
  localparam logic [CFG_W-1:0]     RESET_HEIGHT     = 13'd480;

  // Payload widths.
  localparam int COMP_W       = 8;
  localparam int SAMPLE_W     = 8;
  localparam int PLANE_W      = 2;
  localparam int LUMA_IDX_W   = 24;
  localparam int CHROMA_IDX_W = 22;

  // Arithmetic: signed Q1.15 coefficients.
  localparam int COEF_W    = 16;
  localparam int PROD_W    = COMP_W + 1 + COEF_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int FRAC_BITS = 15;

  localparam logic signed [COEF_W-1:0] CY_R = 16'sd9798;
  localparam logic signed [COEF_W-1:0] CY_G = 16'sd19235;
  localparam logic signed [COEF_W-1:0] CY_B = 16'sd3736;
  localparam logic signed [COEF_W-1:0] CU_R = -16'sd4817;
  localparam logic signed [COEF_W-1:0] CU_G = -16'sd9470;
  localparam logic signed [COEF_W-1:0] CU_B = 16'sd14287;
  localparam logic signed [COEF_W-1:0] CV_R = 16'sd20152;
  localparam logic signed [COEF_W-1:0] CV_G = -16'sd16876;
  localparam logic signed [COEF_W-1:0] CV_B = -16'sd3277;
  localparam logic signed [ACC_W-1:0]  CHROMA_BIAS = 27'sd4194304;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [PLANE_W-1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  // One classified pixel as it waits in the queue.
  typedef struct packed {
    logic [COMP_W-1:0]       red;
    logic [COMP_W-1:0]       green;
    logic [COMP_W-1:0]       blue;
    logic                    chroma;
    logic [LUMA_IDX_W-1:0]   luma_idx;
    logic [CHROMA_IDX_W-1:0] chroma_idx;
    logic                    frame_done;
  } rty_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/rty_pixel_if.sv -----
// Input channel carrying one RGB pixel per transfer.
`default_nettype none

interface rty_pixel_if import rty_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] red;
  logic [COMP_W-1:0] green;
  logic [COMP_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rty_sample_if.sv -----
// Result channel carrying one converted Y, U or V sample per transfer.
`default_nettype none

interface rty_sample_if import rty_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PLANE_W-1:0]    plane;
  logic [SAMPLE_W-1:0]   sample;
  logic [LUMA_IDX_W-1:0] plane_index;
  logic                  last;
  logic                  frame_done;

  modport source (output valid, plane, sample, plane_index, last, frame_done, input ready);
  modport sink   (input valid, plane, sample, plane_index, last, frame_done, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rgb_to_yuv420_converter.sv -----
// Top level of the RGB to YUV 4:2:0 converter.
//
// The converter takes RGB pixels in raster order and returns BT.601-style
// samples on one result channel: a Y sample for every pixel, followed by a U
// and then a V sample for each pixel at an even column of an even row (chroma
// is taken from that top-left pixel, not averaged). Each result carries its
// plane code, the row-major index within its plane, a last flag on the final
// result of the pixel and a frame_done flag on every result of the frame's
// final pixel. The input side accepts one pixel per cycle as long as the
// four-entry queue between the front end and the back end has room; the back
// end produces one result per cycle while the output is not stalled, so a
// chroma pixel takes three results and any other pixel one, and the single
// result port sets the pace. A pixel is registered in the queue, then in the
// product stage and then in the output register. Writing image_width or
// image_height stores the value, clamped to 2..MAX_DIM, and restarts the
// frame; write them only while the converter is idle. There is no clearing
// pass after reset: the converter is ready in the first cycle after reset.
`default_nettype none

module rgb_to_yuv420_converter import rty_pkg::*; #(
  parameter int MAX_DIM = RTY_MAX_DIM
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  rty_pixel_if.sink                 in_pix,
  rty_sample_if.source              out_smp
);

  // Classified pixels pass from the front end through the queue to the back end.
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  rty_item_t q_item;
  rty_item_t q_head;

  // The front end keeps the counters and the dimension registers, and tags
  // each pixel with its plane indices and whether it carries chroma.
  rty_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_pix    (in_pix),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  // The queue lets the input keep flowing while the back end works through
  // the three results of a chroma pixel or waits on a stalled output.
  rty_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // The back end issues one plane per cycle while not stalled into a product
  // stage and a sum-and-clamp stage that ends in the output register.
  rty_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_smp (out_smp)
  );

endmodule

`default_nettype wire

// ----- rtl/core/rty_front.sv -----
// Front end: configuration registers, raster counters and pixel classification.
`default_nettype none

module rty_front import rty_pkg::*; #(
  parameter int MAX_DIM = RTY_MAX_DIM
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  rty_pixel_if.sink                 in_pix,
  input  wire logic                 q_full,
  output logic                      q_push,
  output rty_item_t                 q_item
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int COL_W = $clog2(MAX_DIM);

  // Out-of-range dimensions act as the nearest legal value.
  function automatic logic [DIM_W-1:0] dim_eff(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v < CFG_W'(2)) begin
      res = DIM_W'(2);
    end else if (v > CFG_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = v[DIM_W-1:0];
    end
    return res;
  endfunction

  logic [DIM_W-1:0]        width_r, width_nxt;
  logic [DIM_W-1:0]        height_r, height_nxt;
  logic [COL_W-1:0]        column_r, column_nxt;
  logic [COL_W-1:0]        row_r, row_nxt;
  logic [LUMA_IDX_W-1:0]   luma_addr_r, luma_addr_nxt;
  logic [CHROMA_IDX_W-1:0] chroma_addr_r, chroma_addr_nxt;

  logic accept;
  logic chroma;
  logic row_end;
  logic frame_end;

  assign in_pix.ready = !q_full;
  assign accept       = in_pix.valid && !q_full;

  assign chroma    = !column_r[0] && !row_r[0];
  assign row_end   = (DIM_W'(column_r) + DIM_W'(1)) >= width_r;
  assign frame_end = row_end && ((DIM_W'(row_r) + DIM_W'(1)) >= height_r);

  always_comb begin
    q_push            = accept;
    q_item.red        = in_pix.red;
    q_item.green      = in_pix.green;
    q_item.blue       = in_pix.blue;
    q_item.chroma     = chroma;
    q_item.luma_idx   = luma_addr_r;
    q_item.chroma_idx = chroma_addr_r + CHROMA_IDX_W'(column_r >> 1);
    q_item.frame_done = frame_end;
  end

  always_comb begin
    width_nxt       = width_r;
    height_nxt      = height_r;
    column_nxt      = column_r;
    row_nxt         = row_r;
    luma_addr_nxt   = luma_addr_r;
    chroma_addr_nxt = chroma_addr_r;
    if (cfg_we) begin
      // A register write restarts the frame.
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_nxt  = dim_eff(cfg_wdata);
        CFG_IMAGE_HEIGHT: height_nxt = dim_eff(cfg_wdata);
      endcase
      column_nxt      = '0;
      row_nxt         = '0;
      luma_addr_nxt   = '0;
      chroma_addr_nxt = '0;
    end else if (accept) begin
      priority if (frame_end) begin
        column_nxt      = '0;
        row_nxt         = '0;
        luma_addr_nxt   = '0;
        chroma_addr_nxt = '0;
      end else if (row_end) begin
        // Leaving an odd row moves the chroma base to the next chroma row.
        if (row_r[0]) begin
          chroma_addr_nxt = chroma_addr_r + CHROMA_IDX_W'(width_r >> 1);
        end
        column_nxt    = '0;
        row_nxt       = row_r + COL_W'(1);
        luma_addr_nxt = luma_addr_r + LUMA_IDX_W'(1);
      end else begin
        column_nxt    = column_r + COL_W'(1);
        luma_addr_nxt = luma_addr_r + LUMA_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r       <= dim_eff(RESET_WIDTH);
      height_r      <= dim_eff(RESET_HEIGHT);
      column_r      <= '0;
      row_r         <= '0;
      luma_addr_r   <= '0;
      chroma_addr_r <= '0;
    end else begin
      width_r       <= width_nxt;
      height_r      <= height_nxt;
      column_r      <= column_nxt;
      row_r         <= row_nxt;
      luma_addr_r   <= luma_addr_nxt;
      chroma_addr_r <= chroma_addr_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rty_queue.sv -----
// Short show-ahead queue of classified pixels between the front and the back.
`default_nettype none

module rty_queue import rty_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire rty_item_t  push_item,
  output logic            full,
  input  wire logic       pop,
  output rty_item_t       head,
  output logic            empty
);

  rty_item_t              mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_PTR_W:0]   count_r, count_nxt;

  assign full  = count_r == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QUEUE_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (QUEUE_PTR_W + 1)'(push) - (QUEUE_PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rty_back.sv -----
// Back end: issues Y, and U and V for chroma pixels, multiplies, sums, clamps and drives results.
`default_nettype none

module rty_back import rty_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_empty,
  input  wire rty_item_t q_head,
  output logic           q_pop,
  rty_sample_if.source   out_smp
);

  plane_t state_r, state_nxt;

  logic                     issue;
  logic                     a_ready;
  logic                     b_ready;
  logic signed [COEF_W-1:0] coef_r, coef_g, coef_b;
  logic                     iss_bias;
  logic                     iss_last;
  logic [LUMA_IDX_W-1:0]    iss_index;

  // Product stage.
  logic                     a_valid_r;
  logic signed [PROD_W-1:0] a_pr_r, a_pg_r, a_pb_r;
  logic                     a_bias_r;
  plane_t                   a_plane_r;
  logic [LUMA_IDX_W-1:0]    a_index_r;
  logic                     a_last_r;
  logic                     a_done_r;

  // Sum, clamp and output register.
  logic signed [ACC_W-1:0]       acc;
  logic [ACC_W-FRAC_BITS-2:0]    quot;
  logic [SAMPLE_W-1:0]           clamped;
  logic                          out_valid_r;
  plane_t                        out_plane_r;
  logic [SAMPLE_W-1:0]           out_sample_r;
  logic [LUMA_IDX_W-1:0]         out_index_r;
  logic                          out_last_r;
  logic                          out_done_r;

  assign b_ready = !out_valid_r || out_smp.ready;
  assign a_ready = !a_valid_r || b_ready;
  assign issue   = !q_empty && a_ready;

  // Next plane to issue for the pixel at the queue head.
  always_comb begin
    state_nxt = state_r;
    if (issue) begin
      unique case (state_r)
        PLANE_Y: state_nxt = q_head.chroma ? PLANE_U : PLANE_Y;
        PLANE_U: state_nxt = PLANE_V;
        PLANE_V: state_nxt = PLANE_Y;
        default: state_nxt = PLANE_Y;
      endcase
    end
  end

  always_comb begin
    coef_r    = CY_R;
    coef_g    = CY_G;
    coef_b    = CY_B;
    iss_bias  = 1'b0;
    iss_last  = 1'b1;
    iss_index = q_head.luma_idx;
    unique case (state_r)
      PLANE_Y: begin
        iss_last = !q_head.chroma;
      end
      PLANE_U: begin
        coef_r    = CU_R;
        coef_g    = CU_G;
        coef_b    = CU_B;
        iss_bias  = 1'b1;
        iss_last  = 1'b0;
        iss_index = LUMA_IDX_W'(q_head.chroma_idx);
      end
      PLANE_V: begin
        coef_r    = CV_R;
        coef_g    = CV_G;
        coef_b    = CV_B;
        iss_bias  = 1'b1;
        iss_index = LUMA_IDX_W'(q_head.chroma_idx);
      end
      default: begin
        iss_last = 1'b1;
      end
    endcase
    q_pop = issue && iss_last;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_pr_r    <= $signed({1'b0, q_head.red})   * coef_r;
      a_pg_r    <= $signed({1'b0, q_head.green}) * coef_g;
      a_pb_r    <= $signed({1'b0, q_head.blue})  * coef_b;
      a_bias_r  <= iss_bias;
      a_plane_r <= state_r;
      a_index_r <= iss_index;
      a_last_r  <= iss_last;
      a_done_r  <= q_head.frame_done;
    end
  end

  // Floor by dropping the fraction, then clamp to the sample range.
  always_comb begin
    acc  = ACC_W'(a_pr_r) + ACC_W'(a_pg_r) + ACC_W'(a_pb_r)
         + (a_bias_r ? CHROMA_BIAS : '0);
    quot = acc[ACC_W-2:FRAC_BITS];
    if (acc[ACC_W-1]) begin
      clamped = '0;
    end else if (|quot[ACC_W-FRAC_BITS-2:SAMPLE_W]) begin
      clamped = '1;
    end else begin
      clamped = quot[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      out_plane_r  <= a_plane_r;
      out_sample_r <= clamped;
      out_index_r  <= a_index_r;
      out_last_r   <= a_last_r;
      out_done_r   <= a_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PLANE_Y;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (a_ready) begin
        a_valid_r <= issue;
      end
      if (b_ready) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  assign out_smp.valid       = out_valid_r;
  assign out_smp.plane       = out_plane_r;
  assign out_smp.sample      = out_sample_r;
  assign out_smp.plane_index = out_index_r;
  assign out_smp.last        = out_last_r;
  assign out_smp.frame_done  = out_done_r;

endmodule

`default_nettype wire

// ----- rtl/core/rty_checker.sv -----
// Port-level checker of the converter's result stream, bound to the top level.
`default_nettype none

module rty_checker import rty_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [PLANE_W-1:0]    out_plane,
  input wire logic [SAMPLE_W-1:0]   out_sample,
  input wire logic [LUMA_IDX_W-1:0] out_plane_index,
  input wire logic                  out_last,
  input wire logic                  out_frame_done
);

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_plane) && $stable(out_sample)
      && $stable(out_plane_index) && $stable(out_last) && $stable(out_frame_done))
    else $error("result changed while stalled");

  // Results of one pixel follow back to back in plane order with one frame flag.
  a_pixel_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid
      && (out_plane == PLANE_W'($past(out_plane) + 2'd1))
      && (out_frame_done == $past(out_frame_done)))
    else $error("pixel results broken up");

  a_u_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_plane == PLANE_U) |-> !out_last)
    else $error("U sample flagged last");

  a_v_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_plane == PLANE_V) |-> out_last)
    else $error("V sample not flagged last");

  a_chroma_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_plane == PLANE_U) || (out_plane == PLANE_V))
      |-> (out_plane_index[LUMA_IDX_W-1:CHROMA_IDX_W] == '0))
    else $error("chroma index out of range");

endmodule

bind rgb_to_yuv420_converter rty_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_smp.valid),
  .out_ready       (out_smp.ready),
  .out_plane       (out_smp.plane),
  .out_sample      (out_smp.sample),
  .out_plane_index (out_smp.plane_index),
  .out_last        (out_smp.last),
  .out_frame_done  (out_smp.frame_done)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the RGB to YUV 4:2:0 converter.
`timescale 1ns / 1ps

module testbench;
  import rty_pkg::*;

  // Q1.15 conversion coefficients, kept separate from the package so that a
  // wrong constant in the design cannot hide behind the same wrong constant here.
  localparam int Q_Y_R = 9798;
  localparam int Q_Y_G = 19235;
  localparam int Q_Y_B = 3736;
  localparam int Q_U_R = -4817;
  localparam int Q_U_G = -9470;
  localparam int Q_U_B = 14287;
  localparam int Q_V_R = 20152;
  localparam int Q_V_G = -16876;
  localparam int Q_V_B = -3277;
  localparam int Q_BIAS = 128 * 32768;

  // Run control. The limit is many times the slowest legal run: up to 566
  // pixels, three samples each, every sample waiting out a receiver stall,
  // every pixel behind a sender gap, plus the long hold and the drains.
  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_SLACK   = 8;
  localparam int END_SLACK     = 24;
  localparam int LONG_HOLD     = 80;
  localparam int RANDOM_PHASES = 12;
  localparam int DIRECTED_ROWS = 32;

  typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_RARE} rx_mode_t;

  // One row of stimulus: either a pixel or a register write. A pixel row may
  // carry typed-in sample values that replace the predicted ones.
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_W-1:0]       value;
    logic [COMP_W-1:0]      red;
    logic [COMP_W-1:0]      green;
    logic [COMP_W-1:0]      blue;
    logic                   typed;
    logic [SAMPLE_W-1:0]    y_fixed;
    logic [SAMPLE_W-1:0]    u_fixed;
    logic [SAMPLE_W-1:0]    v_fixed;
  } stim_row_t;

  typedef struct packed {
    plane_t                plane;
    logic [SAMPLE_W-1:0]   sample;
    logic [LUMA_IDX_W-1:0] plane_index;
    logic                  last;
    logic                  frame_done;
  } yuv_sample_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  rty_pixel_if  pix_if ();
  rty_sample_if smp_if ();

  rgb_to_yuv420_converter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_pix    (pix_if),
    .out_smp   (smp_if)
  );

  // 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Samples predicted but not yet seen on the result channel, oldest first.
  yuv_sample_t pending_samples[$];

  // Shadow of the converter's registers and raster position.
  logic [CFG_W-1:0]        shadow_width;
  logic [CFG_W-1:0]        shadow_height;
  logic [11:0]             col_pos;
  logic [11:0]             row_pos;
  logic [LUMA_IDX_W-1:0]   luma_ptr;
  logic [CHROMA_IDX_W-1:0] chroma_row_base;

  // Stimulus-side bookkeeping.
  logic bursty;
  int   burst_left;
  int   pixels_sent;
  int   reg_writes;
  int   hold_requests;

  // Checker-side bookkeeping.
  int mismatches;
  int samples_checked;
  int frames_seen;
  int cycle_count;

  // Directed table. Typed-in values are the ones that can be read straight
  // off the arithmetic: black, white, the primaries, cyan and yellow,
  // including the cases where V saturates high and low. The first nine rows
  // run at the reset size of 640x480 starting from column 0, row 0.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd128, 8'd128},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd255, 8'd0,   8'd0,   1'b1, 8'd76,  8'd90,  8'd255},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd0,   8'd255, 8'd0,   1'b1, 8'd149, 8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd0,   8'd0,   8'd255, 1'b1, 8'd29,  8'd239, 8'd102},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd0,   8'd255, 8'd255, 1'b1, 8'd178, 8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd0,   8'd255, 8'd255, 1'b1, 8'd178, 8'd165, 8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd255, 8'd255, 8'd0,   1'b1, 8'd225, 8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd255, 8'd255, 8'd0,   1'b1, 8'd225, 8'd16,  8'd153},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'h01,  8'h02,  8'h04,  1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'hAA,  8'h55,  8'h80,  1'b0, 8'd0,   8'd0,   8'd0},
    // Dimensions below the floor act as 2: a 2x2 frame, run one pixel past its end.
    '{ROW_CONFIG, CFG_IMAGE_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_CONFIG, CFG_IMAGE_HEIGHT, 13'd1,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd10,  8'd20,  8'd30,  1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd40,  8'd50,  8'd60,  1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd70,  8'd80,  8'd90,  1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd100, 8'd110, 8'd120, 1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd130, 8'd140, 8'd150, 1'b0, 8'd0,   8'd0,   8'd0},
    // Dimensions above the ceiling act as the maximum size.
    '{ROW_CONFIG, CFG_IMAGE_WIDTH,  13'd8191, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_CONFIG, CFG_IMAGE_HEIGHT, 13'd8191, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'h7F,  8'hFE,  8'h01,  1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'h80,  8'h01,  8'hFE,  1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'h55,  8'hAA,  8'h7F,  1'b0, 8'd0,   8'd0,   8'd0},
    // Odd width: the last even column of row 0 and column 0 of row 2 share a
    // chroma index.
    '{ROW_CONFIG, CFG_IMAGE_WIDTH,  13'd3,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_CONFIG, CFG_IMAGE_HEIGHT, 13'd4,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd200, 8'd10,  8'd60,  1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd15,  8'd220, 8'd90,  1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd33,  8'd66,  8'd250, 1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd128, 8'd128, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd1,   8'd254, 8'd3,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd99,  8'd0,   8'd199, 1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    8'd250, 8'd5,   8'd125, 1'b0, 8'd0,   8'd0,   8'd0}
  };

  // A register value below 2 acts as 2 and one above the maximum as the maximum.
  function automatic int effective_dim(input logic [CFG_W-1:0] value);
    if (value < 2) return 2;
    if (value > RTY_MAX_DIM) return RTY_MAX_DIM;
    return int'(value);
  endfunction

  // Floor a Q.15 sum to an integer and saturate it to the sample range.
  function automatic logic [SAMPLE_W-1:0] floor_saturate(input int acc);
    if (acc < 0) return '0;
    if ((acc >>> 15) > 255) return 8'd255;
    return acc[22:15];
  endfunction

  function automatic logic [COMP_W-1:0] random_component();
    // One component in five sits at an extreme of its range.
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return COMP_W'($urandom_range(0, 255));
  endfunction

  // Register values favor small frames so that frame ends happen often, with
  // the occasional value below the floor or above the ceiling.
  function automatic logic [CFG_W-1:0] random_dim();
    case ($urandom_range(0, 9))
      0: return CFG_W'($urandom_range(0, 1));
      1: return CFG_W'($urandom_range(RTY_MAX_DIM + 1, 8191));
      default: return CFG_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic void restart_raster();
    col_pos         = '0;
    row_pos         = '0;
    luma_ptr        = '0;
    chroma_row_base = '0;
  endfunction

  // Work out the samples that one accepted pixel causes, queue them, and
  // advance the raster position.
  function automatic void predict_samples(input stim_row_t px);
    int          wd;
    int          ht;
    logic        is_chroma;
    logic        row_end;
    logic        frame_end;
    int          r;
    int          g;
    int          b;
    yuv_sample_t smp;

    wd        = effective_dim(shadow_width);
    ht        = effective_dim(shadow_height);
    r         = int'(px.red);
    g         = int'(px.green);
    b         = int'(px.blue);
    is_chroma = !col_pos[0] && !row_pos[0];
    row_end   = (int'(col_pos) + 1) >= wd;
    frame_end = row_end && ((int'(row_pos) + 1) >= ht);

    smp.plane       = PLANE_Y;
    smp.sample      = px.typed ? px.y_fixed
                               : floor_saturate(Q_Y_R * r + Q_Y_G * g + Q_Y_B * b);
    smp.plane_index = luma_ptr;
    smp.last        = !is_chroma;
    smp.frame_done  = frame_end;
    pending_samples.push_back(smp);

    if (is_chroma) begin
      // U and V share one chroma index; with an odd width it may repeat.
      smp.plane_index = LUMA_IDX_W'(CHROMA_IDX_W'(chroma_row_base + (col_pos >> 1)));
      smp.plane       = PLANE_U;
      smp.sample      = px.typed ? px.u_fixed
                        : floor_saturate(Q_U_R * r + Q_U_G * g + Q_U_B * b + Q_BIAS);
      smp.last        = 1'b0;
      pending_samples.push_back(smp);
      smp.plane       = PLANE_V;
      smp.sample      = px.typed ? px.v_fixed
                        : floor_saturate(Q_V_R * r + Q_V_G * g + Q_V_B * b + Q_BIAS);
      smp.last        = 1'b1;
      pending_samples.push_back(smp);
    end

    if (frame_end) begin
      restart_raster();
    end else if (row_end) begin
      // The chroma row base moves on only after an odd luma row.
      if (row_pos[0]) chroma_row_base = chroma_row_base + CHROMA_IDX_W'(wd >> 1);
      col_pos  = '0;
      row_pos  = row_pos + 1'b1;
      luma_ptr = luma_ptr + 1'b1;
    end else begin
      col_pos  = col_pos + 1'b1;
      luma_ptr = luma_ptr + 1'b1;
    end
  endfunction

  // Offer one pixel and hold it until the converter takes it. In bursty mode
  // the sender rests for a random gap between bursts of random length.
  task automatic send_pixel(input stim_row_t px);
    int gap;

    if (bursty) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
        @(negedge clk);
        pix_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left--;
    end
    @(negedge clk);
    pix_if.valid <= 1'b1;
    pix_if.red   <= px.red;
    pix_if.green <= px.green;
    pix_if.blue  <= px.blue;
    do @(posedge clk); while (!pix_if.ready);
    predict_samples(px);
    pixels_sent++;
  endtask

  // Stop offering pixels and wait until every predicted sample has come out,
  // then let the pipeline settle.
  task automatic wait_for_results();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Register write; the converter is idle by the time this is called. Any
  // write also restarts the frame.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == CFG_IMAGE_WIDTH) shadow_width = value;
    else shadow_height = value;
    restart_raster();
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver. It stalls on a pattern that changes at random intervals:
  // always ready, coin flip, a fixed one-in-three stall, or rare stalls. When
  // the stimulus asks for it, it holds ready low for a long stretch so the
  // internal queue fills up and back-pressures the input.
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       rx_cycle;
    int       holds_done;

    mode       = RX_ALWAYS;
    mode_left  = 0;
    rx_cycle   = 0;
    holds_done = 0;
    smp_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (hold_requests != holds_done) begin
        smp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          RX_ALWAYS:   smp_if.ready <= 1'b1;
          RX_COIN:     smp_if.ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: smp_if.ready <= (rx_cycle % 3 != 0);
          RX_RARE:     smp_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Checker. Every sample transfer is compared field by field against the
  // oldest prediction.
  always @(posedge clk) begin : sample_checker
    yuv_sample_t want;

    if (rst_n && smp_if.valid && smp_if.ready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected sample: plane %0d sample %0d index %0d",
               smp_if.plane, smp_if.sample, smp_if.plane_index);
        mismatches++;
      end else begin
        want = pending_samples.pop_front();
        samples_checked++;
        if (smp_if.plane != want.plane) begin
          $error("plane: expected %0d, got %0d", want.plane, smp_if.plane);
          mismatches++;
        end
        if (smp_if.sample != want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, smp_if.sample);
          mismatches++;
        end
        if (smp_if.plane_index != want.plane_index) begin
          $error("plane_index: expected %0d, got %0d", want.plane_index, smp_if.plane_index);
          mismatches++;
        end
        if (smp_if.last != want.last) begin
          $error("last: expected %0d, got %0d", want.last, smp_if.last);
          mismatches++;
        end
        if (smp_if.frame_done != want.frame_done) begin
          $error("frame_done: expected %0d, got %0d", want.frame_done, smp_if.frame_done);
          mismatches++;
        end
        if (want.frame_done && want.last) frames_seen++;
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples still pending",
               cycle_count, pending_samples.size());
      $display("FAIL rgb_to_yuv420_converter");
      $finish;
    end
  end

  // Main sequence: reset, the directed table, then random phases, each of
  // which picks new frame dimensions and streams a random number of pixels.
  initial begin : stimulus
    stim_row_t px;
    int        count;

    cycle_count     = 0;
    mismatches      = 0;
    samples_checked = 0;
    frames_seen     = 0;
    pixels_sent     = 0;
    reg_writes      = 0;
    hold_requests   = 0;
    burst_left      = 0;
    bursty          = 1'b1;
    shadow_width    = RESET_WIDTH;
    shadow_height   = RESET_HEIGHT;
    restart_raster();

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_IMAGE_WIDTH;
    cfg_wdata    <= '0;
    pix_if.valid <= 1'b0;
    pix_if.red   <= '0;
    pix_if.green <= '0;
    pix_if.blue  <= '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A register write always waits for the converter to drain.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        wait_for_results();
        write_register(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_pixel(directed_rows[i]);
      end
    end

    // Random part.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      write_register(CFG_IMAGE_WIDTH, random_dim());
      write_register(CFG_IMAGE_HEIGHT, random_dim());
      // The first phase streams back to back while the receiver holds off, so
      // the queue fills and the input must stall; later phases mix bursty and
      // gap-free sending.
      if (phase == 0) begin
        bursty = 1'b0;
        hold_requests++;
      end else begin
        bursty = ($urandom_range(0, 2) != 0);
      end
      burst_left = 0;
      count      = $urandom_range(20, 45);
      for (int i = 0; i < count; i++) begin
        // Once in the run, stop midway through the phase until everything has come out.
        if (phase == 2 && i == count / 2) wait_for_results();
        px       = '0;
        px.kind  = ROW_PIXEL;
        px.red   = random_component();
        px.green = random_component();
        px.blue  = random_component();
        send_pixel(px);
      end
    end

    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (END_SLACK) @(posedge clk);

    $display("Streamed %0d pixels through %0d register writes.", pixels_sent, reg_writes);
    $display("Checked %0d samples, %0d frame ends, %0d mismatches.",
             samples_checked, frames_seen, mismatches);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("PASS rgb_to_yuv420_converter");
    end else begin
      $display("FAIL rgb_to_yuv420_converter");
    end
    $finish;
  end

endmodule

// ----- rgb_to_yuv420_converter.f -----
rtl/core/rty_pkg.sv
rtl/core/rty_pixel_if.sv
rtl/core/rty_sample_if.sv
rtl/core/rty_front.sv
rtl/core/rty_queue.sv
rtl/core/rty_back.sv
rtl/core/rgb_to_yuv420_converter.sv
rtl/core/rty_checker.sv
tb/sv/testbench.sv
